// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg: types and codes for the cursor list engine
// Request and result payloads, command codes and status codes.
// ----------------------------------------------------------------------------
package cle_pkg;

  typedef enum logic [3:0] {
    FUNC_APPEND     = 4'd0,
    FUNC_PREPEND    = 4'd1,
    FUNC_INS_BEFORE = 4'd2,
    FUNC_INS_AFTER  = 4'd3,
    FUNC_DEL_FRONT  = 4'd4,
    FUNC_DEL_BACK   = 4'd5,
    FUNC_DEL_CURSOR = 4'd6,
    FUNC_MV_FRONT   = 4'd7,
    FUNC_MV_BACK    = 4'd8,
    FUNC_MV_PREV    = 4'd9,
    FUNC_MV_NEXT    = 4'd10,
    FUNC_CLEAR      = 4'd11,
    FUNC_QUERY      = 4'd12
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOCURSOR = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         list_length;
    logic               cursor_valid;
    logic [7:0]         cursor_pos;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] cursor_value;
  } rsp_t;

  // One node memory access issued by the sequencer.
  typedef struct packed {
    logic       rd;
    logic       we_val;
    logic       we_prev;
    logic       we_next;
    logic [1:0] rsel;
  } mem_ctl_t;

  localparam logic [1:0] RSEL_VAL  = 2'd0;
  localparam logic [1:0] RSEL_PREV = 2'd1;
  localparam logic [1:0] RSEL_NEXT = 2'd2;

endpackage

// ----- design/cle_node_mem.sv -----
// ----------------------------------------------------------------------------
// cle_node_mem: node storage
// Value, prev and next arrays sharing one address; registered read.
// ----------------------------------------------------------------------------
module cle_node_mem #(
  parameter int unsigned AW = 8,
  parameter int unsigned DW = 32
) (
  input  logic              clk_i,
  input  cle_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DW-1:0]     wval_i,
  input  logic [AW-1:0]     wptr_i,
  output logic [DW-1:0]     rval_o,
  output logic [AW-1:0]     rptr_o
);

  logic [DW-1:0] val_mem  [2**AW];
  logic [AW-1:0] prev_mem [2**AW];
  logic [AW-1:0] next_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_val)  val_mem[addr_i]  <= wval_i;
    if (ctl_i.we_prev) prev_mem[addr_i] <= wptr_i;
    if (ctl_i.we_next) next_mem[addr_i] <= wptr_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rval_o <= val_mem[addr_i];
      rptr_o <= (ctl_i.rsel == cle_pkg::RSEL_PREV) ? prev_mem[addr_i] : next_mem[addr_i];
    end
  end

endmodule

// ----- design/cursor_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// cursor_list_engine_core: doubly linked list with one cursor
// Steps from request accept to result valid: one check and
// allocate step, zero to four node memory steps, three reads of the front,
// back and cursor values, and one step that loads the result register.
// A new request is taken only while idle, so requests do not overlap; a
// result not yet taken holds the sequencer in its last step.
// Reset: asynchronous active low clears list control; node memory is not cleared.
// ----------------------------------------------------------------------------
module cursor_list_engine_core #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  cle_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output cle_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = DATA_WIDTH;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_EXEC  = 10'b0000000010,
    S_M1    = 10'b0000000100,
    S_M2    = 10'b0000001000,
    S_M3    = 10'b0000010000,
    S_M4    = 10'b0000100000,
    S_RDF   = 10'b0001000000,
    S_RDB   = 10'b0010000000,
    S_RDC   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]       func_q, func_d;
  logic [DW-1:0]    val_q, val_d;
  logic [AW-1:0]    head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [AW-1:0]    fhead_q, fhead_d, n_q, n_d, p_q, p_d, nb_q, nb_d;
  logic [CW-1:0]    count_q, count_d, fcount_q, fcount_d, bump_q, bump_d, idx_q, idx_d;
  logic             cv_q, cv_d, out_v_q, out_v_d;
  cle_pkg::status_e st_q, st_d;
  logic [31:0]      fv_q, fv_d, bv_q, bv_d;
  cle_pkg::rsp_t    rsp_q, rsp_d;

  cle_pkg::mem_ctl_t ctl;
  logic [AW-1:0] addr, wptr;
  logic [DW-1:0] wval, rval;
  logic [AW-1:0] rptr;

  cle_node_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i, .ctl_i(ctl), .addr_i(addr), .wval_i(wval), .wptr_i(wptr),
    .rval_o(rval), .rptr_o(rptr)
  );

  function automatic logic [31:0] sext(input logic [DW-1:0] v);
    return 32'(signed'(v));
  endfunction

  logic is_last;
  assign is_last = (idx_q == count_q - ONE);

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_v_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q; func_d = func_q; val_d = val_q;
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; fhead_d = fhead_q;
    n_d = n_q; p_d = p_q; nb_d = nb_q; count_d = count_q; fcount_d = fcount_q;
    bump_d = bump_q; idx_d = idx_q; cv_d = cv_q; st_d = st_q;
    fv_d = fv_q; bv_d = bv_q; rsp_d = rsp_q;
    out_v_d = out_v_q & ~rsp_ready_i;
    ctl = '0; addr = '0; wptr = '0; wval = val_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          func_d = req_i.func;
          val_d = DW'(req_i.value);
          st_d = cle_pkg::ST_OK;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // check preconditions; allocate; pop free list (read next of free head)
        state_d = S_RDF;
        case (func_q)
          cle_pkg::FUNC_APPEND, cle_pkg::FUNC_PREPEND,
          cle_pkg::FUNC_INS_BEFORE, cle_pkg::FUNC_INS_AFTER: begin
            if ((func_q == cle_pkg::FUNC_INS_BEFORE || func_q == cle_pkg::FUNC_INS_AFTER)
                && !cv_q) begin
              st_d = cle_pkg::ST_NOCURSOR;
            end else if (count_q >= CAP) begin
              st_d = cle_pkg::ST_FULL;
            end else begin
              if (fcount_q != '0) begin
                n_d = fhead_q;
                ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_NEXT; addr = fhead_q;
              end else begin
                n_d = bump_q[AW-1:0];
                bump_d = bump_q + ONE;
              end
              state_d = S_M1;
            end
          end
          cle_pkg::FUNC_DEL_FRONT, cle_pkg::FUNC_DEL_BACK, cle_pkg::FUNC_DEL_CURSOR,
          cle_pkg::FUNC_MV_FRONT, cle_pkg::FUNC_MV_BACK: begin
            if (count_q == '0) begin
              st_d = cle_pkg::ST_EMPTY;
            end else if (func_q == cle_pkg::FUNC_DEL_CURSOR && !cv_q) begin
              st_d = cle_pkg::ST_NOCURSOR;
            end else if (func_q == cle_pkg::FUNC_MV_FRONT) begin
              cur_d = head_q; idx_d = '0; cv_d = 1'b1;
            end else if (func_q == cle_pkg::FUNC_MV_BACK) begin
              cur_d = tail_q; idx_d = count_q - ONE; cv_d = 1'b1;
            end else begin
              // pick victim; a cursor at either end reduces to an end delete
              if (func_q == cle_pkg::FUNC_DEL_FRONT ||
                  (func_q == cle_pkg::FUNC_DEL_CURSOR && idx_q == '0)) begin
                n_d = head_q; func_d = cle_pkg::FUNC_DEL_FRONT;
                ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_NEXT; addr = head_q;
              end else if (func_q == cle_pkg::FUNC_DEL_BACK || is_last) begin
                n_d = tail_q; func_d = cle_pkg::FUNC_DEL_BACK;
                ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_PREV; addr = tail_q;
              end else begin
                n_d = cur_q;
                ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_NEXT; addr = cur_q;
              end
              state_d = S_M1;
            end
          end
          cle_pkg::FUNC_MV_PREV, cle_pkg::FUNC_MV_NEXT: begin
            if (cv_q) begin
              if ((func_q == cle_pkg::FUNC_MV_PREV && idx_q == '0) ||
                  (func_q == cle_pkg::FUNC_MV_NEXT && is_last)) begin
                cv_d = 1'b0; idx_d = '0; cur_d = '0;
              end else begin
                ctl.rd = 1'b1; addr = cur_q;
                ctl.rsel = (func_q == cle_pkg::FUNC_MV_PREV) ? cle_pkg::RSEL_PREV
                                                             : cle_pkg::RSEL_NEXT;
                state_d = S_M1;
              end
            end
          end
          cle_pkg::FUNC_CLEAR: begin
            count_d = '0; head_d = '0; tail_d = '0;
            cv_d = 1'b0; idx_d = '0; cur_d = '0;
            fhead_d = '0; fcount_d = '0; bump_d = '0;
          end
          default: ;
        endcase
      end
      S_M1: begin
        case (func_q)
          cle_pkg::FUNC_MV_PREV, cle_pkg::FUNC_MV_NEXT: begin
            cur_d = rptr;
            idx_d = (func_q == cle_pkg::FUNC_MV_PREV) ? idx_q - ONE : idx_q + ONE;
            state_d = S_RDF;
          end
          cle_pkg::FUNC_DEL_FRONT, cle_pkg::FUNC_DEL_BACK: begin
            if (func_q == cle_pkg::FUNC_DEL_FRONT) begin
              if (count_q > ONE) head_d = rptr;
              if (cv_q) begin
                if (idx_q == '0) begin
                  cv_d = 1'b0; idx_d = '0; cur_d = '0;
                end else begin
                  idx_d = idx_q - ONE;
                end
              end
            end else begin
              if (count_q > ONE) tail_d = rptr;
              if (cv_q && is_last) begin
                cv_d = 1'b0; idx_d = '0; cur_d = '0;
              end
            end
            // push victim on the free list
            ctl.we_next = 1'b1; addr = n_q; wptr = fhead_q;
            fhead_d = n_q; fcount_d = fcount_q + ONE;
            count_d = count_q - ONE;
            state_d = S_RDF;
          end
          cle_pkg::FUNC_DEL_CURSOR: begin
            // middle node: p = next; read prev
            p_d = rptr;
            ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_PREV; addr = n_q;
            state_d = S_M2;
          end
          default: begin
            // inserts: finish free pop, write value and the outward link
            if (fcount_q != '0) begin
              fhead_d = rptr; fcount_d = fcount_q - ONE;
            end
            ctl.we_val = 1'b1; addr = n_q;
            if (func_q == cle_pkg::FUNC_PREPEND) begin
              ctl.we_next = 1'b1; wptr = head_q;
            end else if (func_q == cle_pkg::FUNC_INS_BEFORE) begin
              ctl.we_next = 1'b1; wptr = cur_q;
            end else if (func_q == cle_pkg::FUNC_APPEND) begin
              ctl.we_prev = 1'b1; wptr = tail_q;
            end else begin
              ctl.we_prev = 1'b1; wptr = cur_q;
            end
            state_d = S_M2;
          end
        endcase
      end
      S_M2: begin
        case (func_q)
          cle_pkg::FUNC_DEL_CURSOR: begin
            // rptr = prev; next[prev] <= next
            ctl.we_next = 1'b1; addr = rptr; wptr = p_q;
            nb_d = rptr;
            state_d = S_M3;
          end
          cle_pkg::FUNC_APPEND: begin
            count_d = count_q + ONE;
            tail_d = n_q;
            if (count_q == '0) begin
              head_d = n_q;
            end else begin
              ctl.we_next = 1'b1; addr = tail_q; wptr = n_q;
            end
            state_d = S_RDF;
          end
          cle_pkg::FUNC_PREPEND: begin
            count_d = count_q + ONE;
            head_d = n_q;
            if (count_q == '0) begin
              tail_d = n_q;
            end else begin
              ctl.we_prev = 1'b1; addr = head_q; wptr = n_q;
              if (cv_q) idx_d = idx_q + ONE;
            end
            state_d = S_RDF;
          end
          cle_pkg::FUNC_INS_BEFORE: begin
            // read old prev of cursor while linking the new node in
            count_d = count_q + ONE;
            ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_PREV;
            ctl.we_prev = 1'b1; addr = cur_q; wptr = n_q;
            idx_d = idx_q + ONE;
            if (idx_q == '0) begin
              head_d = n_q; state_d = S_RDF;
            end else begin
              state_d = S_M3;
            end
          end
          default: begin
            count_d = count_q + ONE;
            ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_NEXT;
            ctl.we_next = 1'b1; addr = cur_q; wptr = n_q;
            if (is_last) begin
              tail_d = n_q; state_d = S_RDF;
            end else begin
              state_d = S_M3;
            end
          end
        endcase
      end
      S_M3: begin
        case (func_q)
          cle_pkg::FUNC_DEL_CURSOR: begin
            // prev[next] <= prev
            ctl.we_prev = 1'b1; addr = p_q; wptr = nb_q;
            state_d = S_M4;
          end
          cle_pkg::FUNC_INS_BEFORE: begin
            p_d = rptr;
            ctl.we_prev = 1'b1; addr = n_q; wptr = rptr;
            state_d = S_M4;
          end
          default: begin
            p_d = rptr;
            ctl.we_next = 1'b1; addr = n_q; wptr = rptr;
            state_d = S_M4;
          end
        endcase
      end
      S_M4: begin
        state_d = S_RDF;
        case (func_q)
          cle_pkg::FUNC_DEL_CURSOR: begin
            ctl.we_next = 1'b1; addr = n_q; wptr = fhead_q;
            fhead_d = n_q; fcount_d = fcount_q + ONE;
            count_d = count_q - ONE;
            cv_d = 1'b0; cur_d = '0; idx_d = '0;
          end
          cle_pkg::FUNC_INS_BEFORE: begin
            ctl.we_next = 1'b1; addr = p_q; wptr = n_q;
          end
          default: begin
            ctl.we_prev = 1'b1; addr = p_q; wptr = n_q;
          end
        endcase
      end
      S_RDF: begin
        ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_VAL; addr = head_q;
        state_d = S_RDB;
      end
      S_RDB: begin
        fv_d = (count_q != '0) ? sext(rval) : '0;
        ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_VAL; addr = tail_q;
        state_d = S_RDC;
      end
      S_RDC: begin
        bv_d = (count_q != '0) ? sext(rval) : '0;
        ctl.rd = 1'b1; ctl.rsel = cle_pkg::RSEL_VAL; addr = cur_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold until the result register is free
        if (!out_v_q || rsp_ready_i) begin
          rsp_d.status       = st_q;
          rsp_d.list_length  = 9'(count_q);
          rsp_d.cursor_valid = cv_q;
          rsp_d.cursor_pos   = cv_q ? 8'(idx_q) : 8'd0;
          rsp_d.front_value  = fv_q;
          rsp_d.back_value   = bv_q;
          rsp_d.cursor_value = cv_q ? sext(rval) : '0;
          out_v_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      func_q <= '0; val_q <= '0;
      head_q <= '0; tail_q <= '0; cur_q <= '0; fhead_q <= '0;
      n_q <= '0; p_q <= '0; nb_q <= '0;
      count_q <= '0; fcount_q <= '0; bump_q <= '0; idx_q <= '0;
      cv_q <= 1'b0; out_v_q <= 1'b0; st_q <= cle_pkg::ST_OK;
      fv_q <= '0; bv_q <= '0; rsp_q <= '0;
    end else begin
      state_q <= state_d;
      func_q <= func_d; val_q <= val_d;
      head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d; fhead_q <= fhead_d;
      n_q <= n_d; p_q <= p_d; nb_q <= nb_d;
      count_q <= count_d; fcount_q <= fcount_d; bump_q <= bump_d; idx_q <= idx_d;
      cv_q <= cv_d; out_v_q <= out_v_d; st_q <= st_d;
      fv_q <= fv_d; bv_q <= bv_d; rsp_q <= rsp_d;
    end
  end

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q));
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o));
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP);
  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cv_q |-> idx_q < count_q);
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q == S_EXEC);
`endif

endmodule

// ----- bench/cle_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cle_checker: list predictor and result checker
// Watches both channels, mirrors the list in a node array with its own free
// list and bump allocator, and compares each result against the oldest
// expectation.
// ----------------------------------------------------------------------------
module cle_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  cle_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  cle_pkg::rsp_t rsp_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int unsigned CAP = 256;

  logic signed [31:0] nval [CAP];
  logic [7:0]  nprev [CAP];
  logic [7:0]  nnext [CAP];
  logic [7:0]  head, tail, cptr, cidx, fhead;
  logic        cval;
  logic [8:0]  cnt, fcnt, bump;
  cle_pkg::rsp_t expected_q [$];

  function automatic logic [7:0] alloc_node(logic signed [31:0] v);
    logic [7:0] n;
    if (fcnt > 0) begin
      n = fhead;
      fhead = nnext[n];
      fcnt--;
    end else begin
      n = bump[7:0];
      bump++;
    end
    nval[n] = v;
    nprev[n] = 8'hFF;
    nnext[n] = 8'hFF;
    return n;
  endfunction

  function automatic void free_node(logic [7:0] n);
    nnext[n] = fhead;
    fhead = n;
    fcnt++;
  endfunction

  function automatic void drop_cur();
    cval = 1'b0;
    cidx = '0;
    cptr = '0;
  endfunction

  function automatic void pop_front();
    logic [7:0] n;
    n = head;
    if (cnt > 1) head = nnext[n];
    if (cval) begin
      if (cidx == 0) drop_cur();
      else cidx--;
    end
    cnt--;
    free_node(n);
  endfunction

  function automatic void pop_back();
    logic [7:0] n;
    n = tail;
    if (cnt > 1) tail = nprev[n];
    if (cval && cidx == cnt - 1) drop_cur();
    cnt--;
    free_node(n);
  endfunction

  function automatic cle_pkg::rsp_t apply_cmd(cle_pkg::req_t r);
    cle_pkg::rsp_t o;
    cle_pkg::status_e st;
    logic [7:0] n, p;
    st = cle_pkg::ST_OK;
    case (r.func)
      cle_pkg::FUNC_APPEND, cle_pkg::FUNC_PREPEND: begin
        if (cnt >= CAP) st = cle_pkg::ST_FULL;
        else begin
          n = alloc_node(r.value);
          if (cnt == 0) begin
            head = n;
            tail = n;
          end else if (r.func == cle_pkg::FUNC_APPEND) begin
            nprev[n] = tail;
            nnext[tail] = n;
            tail = n;
          end else begin
            nnext[n] = head;
            nprev[head] = n;
            head = n;
            if (cval) cidx++;
          end
          cnt++;
        end
      end
      cle_pkg::FUNC_INS_BEFORE, cle_pkg::FUNC_INS_AFTER: begin
        if (!cval) st = cle_pkg::ST_NOCURSOR;
        else if (cnt >= CAP) st = cle_pkg::ST_FULL;
        else begin
          n = alloc_node(r.value);
          if (r.func == cle_pkg::FUNC_INS_BEFORE) begin
            nnext[n] = cptr;
            if (cidx == 0) head = n;
            else begin
              p = nprev[cptr];
              nprev[n] = p;
              nnext[p] = n;
            end
            nprev[cptr] = n;
            cidx++;
          end else begin
            nprev[n] = cptr;
            if (cidx == cnt - 1) tail = n;
            else begin
              p = nnext[cptr];
              nnext[n] = p;
              nprev[p] = n;
            end
            nnext[cptr] = n;
          end
          cnt++;
        end
      end
      cle_pkg::FUNC_DEL_FRONT, cle_pkg::FUNC_DEL_BACK, cle_pkg::FUNC_DEL_CURSOR,
      cle_pkg::FUNC_MV_FRONT, cle_pkg::FUNC_MV_BACK: begin
        if (cnt == 0) st = cle_pkg::ST_EMPTY;
        else if (r.func == cle_pkg::FUNC_DEL_FRONT) pop_front();
        else if (r.func == cle_pkg::FUNC_DEL_BACK) pop_back();
        else if (r.func == cle_pkg::FUNC_DEL_CURSOR) begin
          if (!cval) st = cle_pkg::ST_NOCURSOR;
          else begin
            if (cidx == 0) pop_front();
            else if (cidx == cnt - 1) pop_back();
            else begin
              n = cptr;
              nnext[nprev[n]] = nnext[n];
              nprev[nnext[n]] = nprev[n];
              cnt--;
              free_node(n);
            end
            drop_cur();
          end
        end else if (r.func == cle_pkg::FUNC_MV_FRONT) begin
          cptr = head;
          cidx = '0;
          cval = 1'b1;
        end else begin
          cptr = tail;
          cidx = 8'(cnt - 1);
          cval = 1'b1;
        end
      end
      cle_pkg::FUNC_MV_PREV: if (cval) begin
        if (cidx == 0) drop_cur();
        else begin
          cptr = nprev[cptr];
          cidx--;
        end
      end
      cle_pkg::FUNC_MV_NEXT: if (cval) begin
        if (cidx == cnt - 1) drop_cur();
        else begin
          cptr = nnext[cptr];
          cidx++;
        end
      end
      cle_pkg::FUNC_CLEAR: begin
        cnt = '0;
        head = '0;
        tail = '0;
        drop_cur();
        fhead = '0;
        fcnt = '0;
        bump = '0;
      end
      default: ;
    endcase
    o.status       = st;
    o.list_length  = cnt;
    o.cursor_valid = cval;
    o.cursor_pos   = cval ? cidx : 8'd0;
    o.front_value  = (cnt != 0) ? nval[head] : 32'sd0;
    o.back_value   = (cnt != 0) ? nval[tail] : 32'sd0;
    o.cursor_value = cval ? nval[cptr] : 32'sd0;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cle_pkg::rsp_t e;
    if (!rst_ni) begin
      head = '0; tail = '0; cptr = '0; cidx = '0; fhead = '0;
      cval = 1'b0; cnt = '0; fcnt = '0; bump = '0;
      fail_count_o <= 0;
      pending_o <= 0;
      expected_q.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", rsp_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (rsp_i !== e) begin
            if (fail_count_o < 10)
              $display("mismatch: expected %p actual %p", e, rsp_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(apply_cmd(req_i));
      pending_o <= expected_q.size();
    end
  end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: cursor list engine testbench
// Directed corner commands, a fill to capacity, then a random command mix,
// with random gaps on both channels; results are checked by cle_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  cle_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cle_pkg::rsp_t rsp;
  int   fails, pending;
  int   idle_cycles = 0;

  always #2 clk = ~clk;

  cursor_list_engine_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  cle_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_i(req_ready), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .fail_count_o(fails), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // response stall
  always @(posedge clk) begin
    if (!rst_n) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(0, 99) < 65);
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // valid stays high across back-to-back requests; drop it only for a gap
  task automatic send(cle_pkg::func_e f, logic signed [31:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req.func  <= f;
    req.value <= v;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_raw(logic [3:0] f, logic signed [31:0] v);
    send(cle_pkg::func_e'(f), v);
  endtask

  function automatic logic signed [31:0] rnd_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'sh7FFFFFFF;
    if (r == 1) return 32'sh80000000;
    if (r == 2) return 32'sd0;
    if (r == 3) return -32'sd1;
    return $urandom();
  endfunction

  initial begin
    int k, i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty-list errors and idle cursor moves
    send(cle_pkg::FUNC_DEL_FRONT, 0); send(cle_pkg::FUNC_DEL_BACK, 0);
    send(cle_pkg::FUNC_DEL_CURSOR, 0);
    send(cle_pkg::FUNC_MV_FRONT, 0); send(cle_pkg::FUNC_MV_BACK, 0);
    send(cle_pkg::FUNC_MV_PREV, 0);
    send(cle_pkg::FUNC_MV_NEXT, 0); send(cle_pkg::FUNC_INS_BEFORE, 5);
    send(cle_pkg::FUNC_APPEND, 32'sh7FFFFFFF); send(cle_pkg::FUNC_PREPEND, 32'sh80000000);
    send(cle_pkg::FUNC_DEL_CURSOR, 0); send(cle_pkg::FUNC_INS_AFTER, 1);
    send(cle_pkg::FUNC_MV_FRONT, 0); send(cle_pkg::FUNC_INS_BEFORE, -1);
    send(cle_pkg::FUNC_INS_AFTER, 0);
    send(cle_pkg::FUNC_MV_NEXT, 0); send(cle_pkg::FUNC_MV_NEXT, 0);
    send(cle_pkg::FUNC_MV_NEXT, 0);
    send(cle_pkg::FUNC_MV_BACK, 0); send(cle_pkg::FUNC_MV_PREV, 0);
    send(cle_pkg::FUNC_DEL_CURSOR, 0);
    send_raw(4'd13, 0); send_raw(4'd15, 0); send(cle_pkg::FUNC_QUERY, 0);
    send(cle_pkg::FUNC_CLEAR, 0);
    // fill to capacity, poke the full case, walk and partly drain
    for (i = 0; i < 256; i++)
      send(i[0] ? cle_pkg::FUNC_APPEND : cle_pkg::FUNC_PREPEND, rnd_val());
    send(cle_pkg::FUNC_APPEND, 1); send(cle_pkg::FUNC_PREPEND, 2);
    send(cle_pkg::FUNC_MV_BACK, 0);
    send(cle_pkg::FUNC_INS_AFTER, 3); send(cle_pkg::FUNC_INS_BEFORE, 4);
    send(cle_pkg::FUNC_MV_NEXT, 0);
    send(cle_pkg::FUNC_MV_BACK, 0); send(cle_pkg::FUNC_DEL_CURSOR, 0);
    for (i = 0; i < 40; i++) send(cle_pkg::FUNC_DEL_FRONT, 0);
    send(cle_pkg::FUNC_CLEAR, 0);
    // random command mix, biased toward inserts and cursor motion
    for (k = 0; k < 400; k++) begin
      i = $urandom_range(0, 99);
      if (i < 30) send(cle_pkg::func_e'($urandom_range(0, 1)), rnd_val());
      else if (i < 50) send(cle_pkg::func_e'($urandom_range(2, 3)), rnd_val());
      else if (i < 65) send(cle_pkg::func_e'($urandom_range(4, 6)), rnd_val());
      else if (i < 92) send(cle_pkg::func_e'($urandom_range(7, 10)), rnd_val());
      else if (i < 94) send(cle_pkg::FUNC_CLEAR, rnd_val());
      else send_raw(4'($urandom_range(12, 15)), rnd_val());
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
